// ===== sv/umrf_pkg.sv =====
package umrf_pkg;

    // One input item: an action code and the received byte.
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] rx_byte;
    } t_in_item;

    // One result item: a message byte and its end marker.
    typedef struct packed {
        logic [7:0] msg_byte;
        logic       last;
    } t_out_item;

    // Action codes of an input item.
    localparam logic [1:0] ACT_BYTE  = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_FETCH = 2'd2;

    // Special characters of the message framing.
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_AT  = 8'h40;

    localparam logic [7:0] THRESHOLD_RESET = 8'd10;
    localparam logic [7:0] TICK_MAX        = 8'hFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_byte;
        logic tick;
        logic clear;
        logic start_read;
        logic idx_inc;
        logic load_data;
        logic load_zero;
        logic pop;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic complete;
        logic pending_expired;
        logic short_msg;
        logic more;
        logic out_last;
    } t_sts;

endpackage

// ===== sv/umrf_ram.sv =====
module umrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/umrf_ctrl.sv =====
module umrf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_action,
    input  logic          i_out_ready,
    input  umrf_pkg::t_sts i_sts,
    output umrf_pkg::t_cmd o_cmd,
    output logic          o_in_ready
);
    import umrf_pkg::*;

    typedef enum logic [1:0] {
        S_ACCEPT,
        S_READ,
        S_LOAD,
        S_SHOW
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_ACCEPT: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_action)
                        ACT_BYTE: begin
                            o_cmd.take_byte = 1'b1;
                        end
                        ACT_TICK: begin
                            o_cmd.tick = 1'b1;
                        end
                        ACT_FETCH: begin
                            if (i_sts.complete) begin
                                if (i_sts.short_msg) begin
                                    o_cmd.load_zero = 1'b1;
                                    n_state         = S_SHOW;
                                end else begin
                                    o_cmd.start_read = 1'b1;
                                    n_state          = S_READ;
                                end
                            end else if (i_sts.pending_expired) begin
                                o_cmd.clear = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                // The store address is presented; data arrives next cycle.
                n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load_data = 1'b1;
                n_state         = S_SHOW;
            end
            S_SHOW: begin
                if (i_out_ready) begin
                    o_cmd.pop = 1'b1;
                    if (i_sts.out_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_ACCEPT;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        if (i_sts.more) begin
                            n_state = S_READ;
                        end else begin
                            o_cmd.load_zero = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_ACCEPT;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACCEPT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/umrf_dp.sv =====
module umrf_dp #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_cfg_wr_en,
    input  logic [7:0]         i_cfg_wr_data,
    input  umrf_pkg::t_cmd     i_cmd,
    output umrf_pkg::t_sts     o_sts,
    output logic               o_out_valid,
    output umrf_pkg::t_out_item o_out_data
);
    import umrf_pkg::*;

    localparam int IW = $clog2(BUFFER_DEPTH);
    localparam int FW = $clog2(BUFFER_DEPTH + 1);
    localparam int CW = FW + 1;

    typedef enum logic [1:0] {
        MS_IDLE,
        MS_PENDING,
        MS_COMPLETE,
        MS_NOTI
    } t_msg_status;

    t_msg_status r_status;
    t_msg_status n_status;
    logic [FW-1:0] r_fill;
    logic [FW-1:0] n_fill;
    logic [7:0]    r_tick;
    logic [7:0]    r_thr;
    logic [IW-1:0] r_idx;
    logic          r_out_valid;
    t_out_item     r_out;

    logic          w_store;
    logic          w_term;
    logic [FW-1:0] w_fill_inc;
    logic [FW-1:0] w_fill_dec;
    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [7:0]    w_wdata;
    logic [7:0]    w_rdata;
    logic [CW-1:0] w_idx_plus2;

    // A byte is stored while collecting and the store has room.
    assign w_store    = (r_status inside {MS_IDLE, MS_PENDING})
                        && (r_fill < FW'(BUFFER_DEPTH));
    assign w_fill_inc = r_fill + FW'(w_store);
    assign w_fill_dec = r_fill - FW'(1);
    assign w_term     = (i_rx_byte inside {CH_NUL, CH_CR})
                        || (w_fill_inc == FW'(BUFFER_DEPTH));

    // A terminator replaces the last stored byte with zero, so one write covers both.
    assign w_we    = i_cmd.take_byte && (w_store || (w_term && (r_fill != '0)));
    assign w_waddr = w_store ? r_fill[IW-1:0] : w_fill_dec[IW-1:0];
    assign w_wdata = w_term ? CH_NUL : i_rx_byte;

    // Status and fill count after a received byte.
    always_comb begin
        n_status = r_status;
        n_fill   = w_fill_inc;
        if (w_term) begin
            n_status = MS_COMPLETE;
        end else if (i_rx_byte == CH_AT) begin
            if (r_status == MS_NOTI) begin
                n_status = MS_IDLE;
                n_fill   = '0;
            end else begin
                n_status = MS_NOTI;
            end
        end else if (r_status inside {MS_IDLE, MS_PENDING}) begin
            n_status = MS_PENDING;
        end
    end

    umrf_ram #(
        .WIDTH(8),
        .DEPTH(BUFFER_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(r_idx),
        .o_rdata(w_rdata)
    );

    // Control registers of the framer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status    <= MS_IDLE;
            r_fill      <= '0;
            r_tick      <= '0;
            r_thr       <= THRESHOLD_RESET;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_thr <= i_cfg_wr_data;
            end
            if (i_cmd.clear) begin
                r_status <= MS_IDLE;
                r_fill   <= '0;
                r_tick   <= '0;
            end else if (i_cmd.take_byte) begin
                r_status <= n_status;
                r_fill   <= n_fill;
                r_tick   <= '0;
            end else if (i_cmd.tick && r_status == MS_PENDING && r_tick != TICK_MAX) begin
                r_tick <= r_tick + 8'd1;
            end
            if (i_cmd.start_read) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.load_data || i_cmd.load_zero) begin
                r_out_valid <= 1'b1;
            end else if (i_cmd.pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload; a zero byte read from the store ends the message.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_data) begin
            r_out.msg_byte <= w_rdata;
            r_out.last     <= (w_rdata == CH_NUL);
        end else if (i_cmd.load_zero) begin
            r_out.msg_byte <= CH_NUL;
            r_out.last     <= 1'b1;
        end
    end

    // Status toward the controller.
    assign w_idx_plus2           = CW'(r_idx) + CW'(2);
    assign o_sts.complete        = (r_status == MS_COMPLETE);
    assign o_sts.pending_expired = (r_status == MS_PENDING) && (r_tick >= r_thr);
    assign o_sts.short_msg       = (r_fill <= FW'(1));
    assign o_sts.more            = (w_idx_plus2 < CW'(r_fill));
    assign o_sts.out_last        = r_out.last;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== sv/uart_message_receive_framer.sv =====
// A received byte, a tick, or a fetch that yields no result is handled in the accept
// state, which stays ready for the next item. A fetch on a complete message passes
// each stored byte through the store read register, output load and output request,
// then the terminator; the next item is accepted the cycle after the last is taken.
// Synchronous active-low reset clears status, counts and output, and sets the
// threshold to 10; the message store is not cleared and needs no clearing pass.
module uart_message_receive_framer #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  umrf_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output umrf_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_wr_en,
    input  logic [7:0]           i_cfg_wr_data
);
    import umrf_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer for item handling and message drain.
    umrf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_data.action),
        .i_out_ready(i_out_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_ready (o_in_ready)
    );

    // Message store, counters and output register.
    umrf_dp #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_byte    (i_in_data.rx_byte),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data)
    );

endmodule

// ===== sv/umrf_chk.sv =====
module umrf_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input umrf_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input umrf_pkg::t_out_item o_out_data
);
    import umrf_pkg::*;

    // A waiting input request holds its payload until it is taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_ready) |=> (i_in_valid && $stable(i_in_data)))
        else $error("input request changed while waiting");

    // A stalled result request holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result request changed while stalled");

    // No new item is taken while a message is being drained.
    a_no_accept_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while a result is pending");

    // The end marker sits exactly on the zero byte.
    a_last_on_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.msg_byte == CH_NUL) == o_out_data.last))
        else $error("end marker and zero byte disagree");

    // After the last byte is taken the drain is over.
    a_drain_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_data.last) |=> (!o_out_valid && o_in_ready))
        else $error("results continue after the end marker");

endmodule

bind uart_message_receive_framer umrf_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .i_in_data  (i_in_data),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);

// ===== verif/uart_message_receive_framer_test.sv =====
`timescale 1ns / 100ps

module uart_message_receive_framer_test;
    import umrf_pkg::*;

    localparam int DEPTH       = 64;
    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 300;
    localparam int PRINT_LIMIT = 50;

    // Action code that the block must ignore.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Message status as the framer tracks it.
    typedef enum logic [1:0] {
        FS_IDLE,
        FS_PENDING,
        FS_COMPLETE,
        FS_NOTIFY
    } t_frame_state;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    t_in_item   in_data     = '0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    t_out_item  out_data;
    logic       cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = '0;

    // Requests waiting to be offered, and bytes the framer still owes us.
    t_in_item  pending_items[$];
    t_out_item msg_bytes_due[$];

    int items_queued = 0;
    int items_taken  = 0;
    int mismatches   = 0;
    int send_gap     = 0;
    int recv_gap     = 0;
    int recv_hold    = 0;
    int quiet_cycles = 0;
    bit hold_wanted  = 1'b0;
    bit hold_started = 1'b0;
    bit no_idle      = 1'b0;

    // Shadow copy of the framer state.
    t_frame_state fr_state;
    int           fr_fill;
    logic [7:0]   fr_age;
    logic [7:0]   fr_limit;
    logic [7:0]   fr_mem [DEPTH];

    uart_message_receive_framer #(
        .BUFFER_DEPTH(DEPTH)
    ) u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_in_data    (in_data),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_out_data   (out_data),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic log_mismatch(input string what);
        if (mismatches < PRINT_LIMIT) begin
            $display("MISMATCH at %0t: %s", $realtime, what);
        end
        mismatches++;
    endtask

    // Empties the message store the way a fetch or a timeout does.
    task automatic drop_frame();
        fr_state = FS_IDLE;
        fr_fill  = 0;
        fr_age   = '0;
    endtask

    // Applies one accepted request to the shadow state and queues the bytes it yields.
    task automatic advance_framer(input t_in_item it);
        t_out_item res;
        case (it.action)
            ACT_BYTE: begin
                fr_age = '0;
                if ((fr_state inside {FS_IDLE, FS_PENDING}) && fr_fill < DEPTH) begin
                    fr_mem[fr_fill] = it.rx_byte;
                    fr_fill++;
                end
                if ((it.rx_byte inside {CH_NUL, CH_CR}) || fr_fill >= DEPTH) begin
                    // The last stored byte turns into the terminator.
                    if (fr_fill > 0) begin
                        fr_mem[fr_fill - 1] = CH_NUL;
                    end
                    fr_state = FS_COMPLETE;
                end else if (it.rx_byte == CH_AT) begin
                    if (fr_state == FS_NOTIFY) begin
                        fr_state  = FS_IDLE;
                        fr_mem[0] = CH_NUL;
                        fr_fill   = 0;
                    end else begin
                        fr_state = FS_NOTIFY;
                    end
                end else if (fr_state inside {FS_IDLE, FS_PENDING}) begin
                    fr_state = FS_PENDING;
                end
            end
            ACT_TICK: begin
                if (fr_state == FS_PENDING && fr_age != TICK_MAX) begin
                    fr_age = fr_age + 8'd1;
                end
            end
            ACT_FETCH: begin
                if (fr_state == FS_COMPLETE) begin
                    for (int k = 0; k + 1 < fr_fill; k++) begin
                        if (fr_mem[k] == CH_NUL) begin
                            break;
                        end
                        res.msg_byte = fr_mem[k];
                        res.last     = 1'b0;
                        msg_bytes_due.push_back(res);
                    end
                    res.msg_byte = CH_NUL;
                    res.last     = 1'b1;
                    msg_bytes_due.push_back(res);
                    drop_frame();
                end else if (fr_state == FS_PENDING && fr_age >= fr_limit) begin
                    drop_frame();
                end
            end
            default: begin
            end
        endcase
    endtask

    // Request driver: holds each request until it is taken, with random gaps.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                advance_framer(in_data);
                items_taken++;
            end
            if (!in_valid || in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    in_data  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                    if (!no_idle && $urandom_range(0, 5) == 0) begin
                        send_gap = $urandom_range(1, 6);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each taken byte against the oldest one owed.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (msg_bytes_due.size() == 0) begin
                    log_mismatch($sformatf("unexpected byte %h last %b",
                                           out_data.msg_byte, out_data.last));
                end else begin
                    if (out_data.msg_byte !== msg_bytes_due[0].msg_byte) begin
                        log_mismatch($sformatf("msg_byte %h, wanted %h",
                                               out_data.msg_byte, msg_bytes_due[0].msg_byte));
                    end
                    if (out_data.last !== msg_bytes_due[0].last) begin
                        log_mismatch($sformatf("last %b, wanted %b",
                                               out_data.last, msg_bytes_due[0].last));
                    end
                    void'(msg_bytes_due.pop_front());
                end
            end
            // One long hold-off lets the framer back up and stall its input.
            if (hold_wanted && !hold_started) begin
                hold_started = 1'b1;
                recv_hold    = LONG_HOLD;
            end
            if (recv_hold > 0) begin
                recv_hold--;
                out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 5) == 0) begin
                    recv_gap = $urandom_range(1, 6);
                end
            end
        end
    end

    // Watchdog on cycles where neither side moves anything.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TIMEOUT after %0d idle cycles", quiet_cycles);
            $display("uart_message_receive_framer verification failed");
            $finish;
        end
    end

    task automatic push_item(input logic [1:0] action, input logic [7:0] value);
        t_in_item it;
        it.action  = action;
        it.rx_byte = value;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Random message text, free of the framing characters.
    function automatic logic [7:0] pick_text();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while (b inside {CH_NUL, CH_CR, CH_AT});
        return b;
    endfunction

    // Waits until every request is taken and every owed byte has come out.
    task automatic settle();
        while (items_taken != items_queued || msg_bytes_due.size() != 0) begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_limit(input logic [7:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        fr_limit = value;
    endtask

    // One random traffic pattern; seven of the sixteen draws give a well-formed message.
    task automatic queue_scenario();
        int len;
        int n;
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4, 5, 6: begin
                len = $urandom_range(0, 10);
                repeat (len) begin
                    push_item(ACT_BYTE, pick_text());
                    if ($urandom_range(0, 5) == 0) begin
                        push_item(ACT_TICK, 8'($urandom));
                    end
                end
                push_item(ACT_BYTE, $urandom_range(0, 1) ? CH_NUL : CH_CR);
                if ($urandom_range(0, 3) == 0) begin
                    push_item(ACT_BYTE, 8'($urandom));
                end
                push_item(ACT_FETCH, 8'($urandom));
            end
            7, 8: begin
                if ($urandom_range(0, 1)) begin
                    repeat ($urandom_range(1, 3)) push_item(ACT_BYTE, pick_text());
                end
                push_item(ACT_BYTE, CH_AT);
                repeat ($urandom_range(0, 5)) push_item(ACT_BYTE, pick_text());
                push_item(ACT_BYTE, ($urandom_range(0, 3) != 0) ? CH_AT : CH_NUL);
                push_item(ACT_FETCH, 8'($urandom));
            end
            9, 10: begin
                // Age a pending message to around a threshold of up to 40, then fetch.
                repeat ($urandom_range(1, 3)) push_item(ACT_BYTE, pick_text());
                if (fr_limit <= 40) begin
                    n = int'(fr_limit) - 1 + $urandom_range(0, 2);
                end else begin
                    n = $urandom_range(0, 8);
                end
                repeat (n) push_item(ACT_TICK, 8'($urandom));
                push_item(ACT_FETCH, 8'($urandom));
                if ($urandom_range(0, 1)) begin
                    push_item(ACT_FETCH, 8'($urandom));
                end
            end
            11, 12: begin
                repeat ($urandom_range(4, 10)) begin
                    push_item(2'($urandom_range(0, 3)), 8'($urandom));
                end
            end
            13: begin
                len = $urandom_range(60, 70);
                repeat (len) push_item(ACT_BYTE, pick_text());
                push_item(ACT_BYTE, CH_CR);
                push_item(ACT_FETCH, 8'($urandom));
            end
            default: begin
                // A notification that opens on a complete message throws it away.
                push_item(ACT_BYTE, pick_text());
                push_item(ACT_BYTE, CH_NUL);
                push_item(ACT_BYTE, CH_AT);
                push_item(ACT_BYTE, pick_text());
                push_item(ACT_BYTE, CH_AT);
                push_item(ACT_FETCH, 8'($urandom));
            end
        endcase
    endtask

    task automatic run_random(input int count);
        int stop_at;
        stop_at = items_queued + count;
        while (items_queued < stop_at) begin
            queue_scenario();
        end
    endtask

    initial begin
        drop_frame();
        fr_limit = THRESHOLD_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Fetch with nothing stored, then a terminator on an empty store.
        push_item(ACT_FETCH, 8'h00);
        push_item(ACT_BYTE, CH_NUL);
        push_item(ACT_FETCH, 8'hFF);
        // Extreme byte values, ended by CR.
        push_item(ACT_BYTE, 8'h41);
        push_item(ACT_BYTE, 8'hFF);
        push_item(ACT_BYTE, 8'h01);
        push_item(ACT_BYTE, CH_CR);
        push_item(ACT_FETCH, 8'h00);
        // Tick while idle and the unused action code.
        push_item(ACT_TICK, 8'h00);
        push_item(ACT_UNUSED, 8'hFF);
        // A bare notification leaves nothing behind.
        push_item(ACT_BYTE, CH_AT);
        push_item(ACT_BYTE, 8'h7E);
        push_item(ACT_BYTE, CH_AT);
        push_item(ACT_FETCH, 8'h00);
        // Bytes inside an open notification are dropped; NUL still ends it.
        push_item(ACT_BYTE, 8'h71);
        push_item(ACT_BYTE, CH_AT);
        push_item(ACT_BYTE, 8'h7A);
        push_item(ACT_BYTE, CH_NUL);
        push_item(ACT_FETCH, 8'h00);
        // An '@' on a complete empty message, closed again.
        push_item(ACT_BYTE, CH_NUL);
        push_item(ACT_BYTE, CH_AT);
        push_item(ACT_BYTE, 8'h33);
        push_item(ACT_BYTE, CH_AT);
        push_item(ACT_FETCH, 8'h00);
        run_random(20);
        settle();

        // Smallest threshold, with the receiver held off over a full store.
        write_limit(8'd1);
        hold_wanted = 1'b1;
        repeat (65) push_item(ACT_BYTE, pick_text());
        push_item(ACT_FETCH, 8'h00);
        run_random(15);
        settle();

        // Largest threshold: the tick count must stop at its ceiling.
        write_limit(8'd255);
        push_item(ACT_BYTE, pick_text());
        repeat (254) push_item(ACT_TICK, 8'h00);
        push_item(ACT_FETCH, 8'h00);
        repeat (2) push_item(ACT_TICK, 8'h00);
        push_item(ACT_FETCH, 8'h00);
        push_item(ACT_BYTE, CH_NUL);
        push_item(ACT_FETCH, 8'h00);
        settle();

        write_limit(8'($urandom_range(2, 254)));
        run_random(10);
        settle();

        // Final stretch runs without any idling on either side.
        no_idle = 1'b1;
        write_limit(THRESHOLD_RESET);
        run_random(15);
        settle();
        repeat (16) @(posedge clk);

        if (msg_bytes_due.size() != 0) begin
            log_mismatch($sformatf("%0d bytes never came out", msg_bytes_due.size()));
        end
        if (mismatches == 0) begin
            $display("uart_message_receive_framer verification clean");
        end else begin
            $display("uart_message_receive_framer verification failed");
        end
        $finish;
    end

endmodule
